### sv/fir12_pkg.sv
// Shared constants, control types and state encoding for the 12-tap FIR filter.
package fir12_pkg;

   localparam int TAPS_DEF        = 12;
   localparam int SAMPLE_BITS_DEF = 12;
   localparam int COEF_BITS_DEF   = 16;
   localparam int COEF_INDEX_W    = 4;
   localparam int FILTERED_W      = 32;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_COEF   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MAC,
      ST_DRAIN,
      ST_FINISH
   } fir12_state_type;

   typedef struct packed {
      logic shift_in;
      logic load_coef;
      logic rotate;
      logic mac_clear;
      logic mac_en;
      logic rsp_load;
   } fir12_ctrl_type;

endpackage

### sv/fir12_taps.sv
// Delay line and coefficient store, both rotating past one fixed read position.
module fir12_taps #(
   parameter int TAPS        = fir12_pkg::TAPS_DEF,
   parameter int SAMPLE_BITS = fir12_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fir12_pkg::COEF_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fir12_pkg::fir12_ctrl_type           ctrl,
   input  logic [SAMPLE_BITS-1:0]              sample,
   input  logic [fir12_pkg::COEF_INDEX_W-1:0]  coef_index,
   input  logic signed [COEF_BITS-1:0]         coef_value,
   output logic [SAMPLE_BITS-1:0]              line_head,
   output logic signed [COEF_BITS-1:0]         coef_head
);
   import fir12_pkg::*;

   localparam int TAP_IDX_W = $clog2(TAPS);

   logic [SAMPLE_BITS-1:0]      line_ff [TAPS];
   logic [SAMPLE_BITS-1:0]      line_in [TAPS];
   logic signed [COEF_BITS-1:0] coef_ff [TAPS];
   logic signed [COEF_BITS-1:0] coef_in [TAPS];
   logic [TAP_IDX_W-1:0]        wr_idx;

   assign wr_idx = TAP_IDX_W'(coef_index);

   // Both arrays rotate together during a filter pass, so after TAPS steps
   // every entry is back where it started.
   always_comb begin
      line_in = line_ff;
      coef_in = coef_ff;
      if (ctrl.shift_in) begin
         for (int k = TAPS - 1; k > 0; k--) begin
            line_in[k] = line_ff[k-1];
         end
         line_in[0] = sample;
      end else if (ctrl.rotate) begin
         for (int k = 0; k < TAPS - 1; k++) begin
            line_in[k] = line_ff[k+1];
            coef_in[k] = coef_ff[k+1];
         end
         line_in[TAPS-1] = line_ff[0];
         coef_in[TAPS-1] = coef_ff[0];
      end
      if (ctrl.load_coef) begin
         coef_in[wr_idx] = coef_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS; k++) begin
            line_ff[k] <= '0;
            coef_ff[k] <= '0;
         end
      end else begin
         line_ff <= line_in;
         coef_ff <= coef_in;
      end
   end

   assign line_head = line_ff[0];
   assign coef_head = coef_ff[0];

endmodule

### sv/fir12_mac.sv
// Shared multiplier with a registered product, the accumulator and the result register.
module fir12_mac #(
   parameter int TAPS        = fir12_pkg::TAPS_DEF,
   parameter int SAMPLE_BITS = fir12_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fir12_pkg::COEF_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fir12_pkg::fir12_ctrl_type                ctrl,
   input  logic [SAMPLE_BITS-1:0]                   line_head,
   input  logic signed [COEF_BITS-1:0]              coef_head,
   output logic signed [fir12_pkg::FILTERED_W-1:0]  filtered
);
   import fir12_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + 1 + COEF_BITS;
   localparam int ACC_W  = PROD_W + $clog2(TAPS);

   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [PROD_W-1:0]     prod_in;
   logic                         prod_valid_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_in;
   logic signed [FILTERED_W-1:0] acc_out;
   logic signed [FILTERED_W-1:0] filtered_ff;

   // The sample is unsigned, so it gets a zero sign bit before the signed multiply.
   assign prod_in = PROD_W'($signed({1'b0, line_head})) * PROD_W'(coef_head);

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.mac_clear) begin
         acc_in = '0;
      end else if (prod_valid_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   // Narrow configurations sign-extend; wide ones keep the low bits, which can wrap.
   generate
      if (ACC_W >= FILTERED_W) begin : g_trunc
         assign acc_out = acc_ff[FILTERED_W-1:0];
      end else begin : g_extend
         assign acc_out = FILTERED_W'(acc_ff);
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else begin
         prod_valid_ff <= ctrl.mac_en;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.mac_en) begin
         prod_ff <= prod_in;
      end
      acc_ff <= acc_in;
      if (ctrl.rsp_load) begin
         filtered_ff <= acc_out;
      end
   end

   assign filtered = filtered_ff;

endmodule

### sv/fir12_ctrl.sv
// Sequencer that steps the shared multiplier over the taps and owns the handshakes.
module fir12_ctrl #(
   parameter int TAPS = fir12_pkg::TAPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_kind,
   input  logic [fir12_pkg::COEF_INDEX_W-1:0]  req_coef_index,
   output logic                                req_ready,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output fir12_pkg::fir12_ctrl_type           ctrl
);
   import fir12_pkg::*;

   localparam int CNT_W = $clog2(TAPS);

   fir12_state_type state_ff;
   fir12_state_type state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             accept;
   logic             in_range;
   logic             last_tap;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign in_range = (32'(req_coef_index) < 32'(TAPS));
   assign last_tap = (count_ff == CNT_W'(TAPS - 1));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_kind == KIND_SAMPLE) begin
               state_in = ST_MAC;
            end
         end
         ST_MAC: begin
            if (last_tap) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready      = (state_ff == ST_IDLE);
      ctrl.shift_in  = accept && (req_kind == KIND_SAMPLE);
      ctrl.mac_clear = accept && (req_kind == KIND_SAMPLE);
      ctrl.load_coef = accept && (req_kind == KIND_COEF) && in_range;
      ctrl.rotate    = (state_ff == ST_MAC);
      ctrl.mac_en    = (state_ff == ST_MAC);
      ctrl.rsp_load  = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_ready);
   end

   always_comb begin
      count_in = '0;
      if (state_ff == ST_MAC) begin
         count_in = count_ff + CNT_W'(1);
      end
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### sv/fir_filter_12_tap.sv
// A direct-form FIR filter whose single multiplier is stepped over the taps by a sequencer. A
// coefficient beat (kind 1) writes one signed coefficient; a tap number at or above TAPS is
// dropped. A sample beat (kind 0) shifts the sample into the delay line and then runs a pass
// before the next beat is taken: the shared multiply-accumulate over all TAPS taps, a drain of
// the product register, then a move of the sum to the result register, which stalls while an
// earlier result is not yet taken. req_ready is low for that whole pass. The result register
// holds the last sum until it is taken, and new beats are accepted while it waits. The sum is
// exact; it is given as the low 32 bits, which wrap only well above the default parameters.
module fir_filter_12_tap #(
   parameter int TAPS        = fir12_pkg::TAPS_DEF,
   parameter int SAMPLE_BITS = fir12_pkg::SAMPLE_BITS_DEF,
   parameter int COEF_BITS   = fir12_pkg::COEF_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic                                     req_kind,
   input  logic [SAMPLE_BITS-1:0]                   req_sample,
   input  logic [fir12_pkg::COEF_INDEX_W-1:0]       req_coef_index,
   input  logic signed [COEF_BITS-1:0]              req_coef_value,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [fir12_pkg::FILTERED_W-1:0]  rsp_filtered
);
   import fir12_pkg::*;

   fir12_ctrl_type              ctrl;
   logic [SAMPLE_BITS-1:0]      line_head;
   logic signed [COEF_BITS-1:0] coef_head;

   fir12_ctrl #(
      .TAPS (TAPS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_kind       (req_kind),
      .req_coef_index (req_coef_index),
      .req_ready      (req_ready),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .ctrl           (ctrl)
   );

   fir12_taps #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_taps (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .sample     (req_sample),
      .coef_index (req_coef_index),
      .coef_value (req_coef_value),
      .line_head  (line_head),
      .coef_head  (coef_head)
   );

   fir12_mac #(
      .TAPS        (TAPS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .COEF_BITS   (COEF_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .line_head (line_head),
      .coef_head (coef_head),
      .filtered  (rsp_filtered)
   );

endmodule

### sv/fir12_checker.sv
// Port-level checks on the FIR filter's handshakes and sequencing, bound to the top level.
module fir12_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_kind,
   input logic rsp_valid,
   input logic rsp_ready
);
   import fir12_pkg::*;

   // A result beat stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the result beat was taken");

   // A sample beat starts a filter pass, so the block must stop taking beats.
   a_sample_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_SAMPLE) |=> !req_ready)
      else $error("block still ready in the cycle after a sample beat");

   // A coefficient beat leaves the block ready.
   a_coef_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == KIND_COEF) |=> req_ready)
      else $error("block not ready after a coefficient beat");

   // A new result appears only as the pass ends, when the block turns ready again.
   a_rsp_at_end: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("result beat offered while a filter pass is still running");

endmodule

bind fir_filter_12_tap fir12_checker u_fir12_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_kind  (req_kind),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready)
);

### test/fir_filter_12_tap_checker.sv
// Checker for the 12-tap FIR filter: watches both channels, predicts each filtered beat and compares.
`timescale 1ns / 100ps

module fir_filter_12_tap_checker (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   input  logic                                        req_ready,
   input  logic                                        req_kind,
   input  logic [fir12_pkg::SAMPLE_BITS_DEF-1:0]       req_sample,
   input  logic [fir12_pkg::COEF_INDEX_W-1:0]          req_coef_index,
   input  logic signed [fir12_pkg::COEF_BITS_DEF-1:0]  req_coef_value,
   input  logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   input  logic signed [fir12_pkg::FILTERED_W-1:0]     rsp_filtered,
   output int                                          error_count,
   output int                                          expected_left
);
   import fir12_pkg::*;

   logic [SAMPLE_BITS_DEF-1:0]      tap_samples [TAPS_DEF];
   logic signed [COEF_BITS_DEF-1:0] tap_coefs [TAPS_DEF];
   logic signed [FILTERED_W-1:0]    expected_filtered [$];
   logic signed [FILTERED_W-1:0]    want;

   // Exact sum of products over the delay line, kept to the low result bits.
   function automatic logic signed [FILTERED_W-1:0] filter_output();
      longint acc;
      acc = 0;
      for (int k = 0; k < TAPS_DEF; k++)
         acc += longint'(tap_coefs[k]) * longint'(tap_samples[k]);
      return acc[FILTERED_W-1:0];
   endfunction

   initial begin
      error_count   = 0;
      expected_left = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < TAPS_DEF; k++) begin
            tap_samples[k] = '0;
            tap_coefs[k]   = '0;
         end
         expected_filtered.delete();
      end else begin
         // A result beat always belongs to a sample taken at an earlier edge.
         if (rsp_valid && rsp_ready) begin
            if (expected_filtered.size() == 0) begin
               $display("%0t: result beat with nothing expected: expected none, actual %0d",
                        $time, rsp_filtered);
               error_count++;
            end else begin
               want = expected_filtered.pop_front();
               if (rsp_filtered !== want) begin
                  $display("%0t: filtered mismatch: expected %0d, actual %0d",
                           $time, want, rsp_filtered);
                  error_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_COEF) begin
               if (req_coef_index < TAPS_DEF)
                  tap_coefs[req_coef_index] = req_coef_value;
            end else begin
               for (int k = TAPS_DEF - 1; k > 0; k--)
                  tap_samples[k] = tap_samples[k-1];
               tap_samples[0] = req_sample;
               expected_filtered.push_back(filter_output());
            end
         end
      end
      expected_left <= expected_filtered.size();
   end

endmodule

### test/fir_filter_12_tap_tb.sv
// Testbench top for the 12-tap FIR filter: clock, reset, stimulus, receiver and verdict.
`timescale 1ns / 100ps

module fir_filter_12_tap_tb;
   import fir12_pkg::*;

   localparam int HOLD_CYCLES  = 300;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 4 * (TAPS_DEF + 3);

   logic                            clock          = 1'b0;
   logic                            reset          = 1'b1;
   logic                            req_valid      = 1'b0;
   logic                            req_ready;
   logic                            req_kind       = KIND_SAMPLE;
   logic [SAMPLE_BITS_DEF-1:0]      req_sample     = '0;
   logic [COEF_INDEX_W-1:0]         req_coef_index = '0;
   logic signed [COEF_BITS_DEF-1:0] req_coef_value = '0;
   logic                            rsp_valid;
   logic                            rsp_ready      = 1'b0;
   logic signed [FILTERED_W-1:0]    rsp_filtered;

   int error_count;
   int expected_left;
   int send_idle_pct = 15;
   int recv_idle_pct = 56;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int idle_cycles;

   fir_filter_12_tap DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_sample     (req_sample),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered)
   );

   fir_filter_12_tap_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_kind       (req_kind),
      .req_sample     (req_sample),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_filtered   (rsp_filtered),
      .error_count    (error_count),
      .expected_left  (expected_left)
   );

   always #5 clock = ~clock;

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Receiver: random back-pressure, plus one long hold-off on request so the filter backs up.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   initial begin
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("fir_filter_12_tap test failed");
      $finish;
   end

   // Offers one beat, after an optional random gap, and returns at the edge that takes it.
   task automatic send_beat(input logic kind, input logic [SAMPLE_BITS_DEF-1:0] smp,
                            input logic [COEF_INDEX_W-1:0] idx,
                            input logic signed [COEF_BITS_DEF-1:0] cval);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_sample     <= smp;
      req_coef_index <= idx;
      req_coef_value <= cval;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
   endtask

   task automatic load_coef(input logic [COEF_INDEX_W-1:0] idx,
                            input logic signed [COEF_BITS_DEF-1:0] cval);
      send_beat(KIND_COEF, SAMPLE_BITS_DEF'($urandom), idx, cval);
   endtask

   task automatic push_sample(input logic [SAMPLE_BITS_DEF-1:0] smp);
      send_beat(KIND_SAMPLE, smp, COEF_INDEX_W'($urandom), COEF_BITS_DEF'($urandom));
   endtask

   function automatic logic signed [COEF_BITS_DEF-1:0] pick_coef();
      case ($urandom_range(9))
         0:       return 16'sh7FFF;
         1:       return 16'sh8000;
         2:       return '0;
         default: return COEF_BITS_DEF'($urandom);
      endcase
   endfunction

   function automatic logic [SAMPLE_BITS_DEF-1:0] pick_sample();
      case ($urandom_range(9))
         0:       return '1;
         1:       return '0;
         default: return SAMPLE_BITS_DEF'($urandom);
      endcase
   endfunction

   // Mix of coefficient reloads, sample runs, full-scale fills and ignored out-of-range loads.
   task automatic run_random(input int count);
      int done;
      int pick;
      logic signed [COEF_BITS_DEF-1:0] cval;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            repeat ($urandom_range(1, TAPS_DEF)) begin
               load_coef(COEF_INDEX_W'($urandom_range(TAPS_DEF - 1)), pick_coef());
               done++;
            end
         end else if (pick < 85) begin
            repeat ($urandom_range(1, 20)) begin
               push_sample(pick_sample());
               done++;
            end
         end else if (pick < 92) begin
            // Every tap at full scale of one sign drives the sum to its extreme.
            cval = ($urandom_range(1) != 0) ? 16'sh7FFF : 16'sh8000;
            for (int k = 0; k < TAPS_DEF; k++)
               load_coef(COEF_INDEX_W'(k), cval);
            repeat (TAPS_DEF + 2) push_sample('1);
            done += 2 * TAPS_DEF + 2;
         end else begin
            repeat ($urandom_range(1, 3)) begin
               load_coef(COEF_INDEX_W'($urandom_range(TAPS_DEF, 15)), COEF_BITS_DEF'($urandom));
               done++;
            end
         end
      end
   endtask

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);

      // Filtering before any load gives zero; out-of-range tap numbers change nothing.
      push_sample('1);
      push_sample('0);
      load_coef(COEF_INDEX_W'(TAPS_DEF), 16'sh7FFF);
      load_coef(4'hF, 16'sh8000);
      push_sample('1);
      load_coef(4'd0, 16'sh7FFF);
      load_coef(COEF_INDEX_W'(TAPS_DEF - 1), 16'sh8000);
      load_coef(4'd5, -16'sd1);
      load_coef(4'd1, 16'sh5555);
      push_sample('1);
      for (int k = 1; k < TAPS_DEF; k++)
         push_sample((k % 2) ? 12'hAAA : 12'h555);

      run_random(320);
      send_idle_pct = 56;
      recv_idle_pct = 15;
      run_random(320);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests <= hold_requests + 1;
      run_random(310);
      req_valid <= 1'b0;

      while (expected_left != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && expected_left == 0)
         $display("fir_filter_12_tap test passed");
      else
         $display("fir_filter_12_tap test failed");
      $finish;
   end

endmodule
